[design/sdsh_pkg.sv]
// Shared types and constants for the SD SPI host sequencer.
package sdsh_pkg;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_XCHG  = 3'd3,
        CMD_WBYTE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        K_XFER  = 2'd0,
        K_RDATA = 2'd1,
        K_WREQ  = 2'd2,
        K_DONE  = 2'd3
    } t_kind;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic [0:0] REG_ALIGN = 1'd0;
    localparam logic [0:0] REG_RETRY = 1'd1;

    typedef enum logic [33:0] {
        P_IDLE     = 34'd1 << 0,
        P_I_WAKE   = 34'd1 << 1,
        P_I_GAP    = 34'd1 << 2,
        P_I_CMD0   = 34'd1 << 3,
        P_I_POLL0  = 34'd1 << 4,
        P_I_DUMMY0 = 34'd1 << 5,
        P_I_GAP2   = 34'd1 << 6,
        P_I_CMD55  = 34'd1 << 7,
        P_I_POLL55 = 34'd1 << 8,
        P_I_DUM55  = 34'd1 << 9,
        P_I_GAP55  = 34'd1 << 10,
        P_I_ACMD41 = 34'd1 << 11,
        P_I_POLL41 = 34'd1 << 12,
        P_I_DUM41  = 34'd1 << 13,
        P_I_GAP41  = 34'd1 << 14,
        P_I_CMD16  = 34'd1 << 15,
        P_I_POLL16 = 34'd1 << 16,
        P_FINAL    = 34'd1 << 17,
        P_SETTLE   = 34'd1 << 18,
        P_R_CMD17  = 34'd1 << 19,
        P_R_POLL   = 34'd1 << 20,
        P_R_DUMMY  = 34'd1 << 21,
        P_R_TOKEN  = 34'd1 << 22,
        P_R_DATA   = 34'd1 << 23,
        P_R_DRAIN  = 34'd1 << 24,
        P_W_CMD24  = 34'd1 << 25,
        P_W_POLL   = 34'd1 << 26,
        P_W_DUMMY  = 34'd1 << 27,
        P_W_SKIP   = 34'd1 << 28,
        P_W_REQ    = 34'd1 << 29,
        P_W_XFER   = 34'd1 << 30,
        P_W_RESP   = 34'd1 << 31,
        P_W_BUSY   = 34'd1 << 32,
        P_DONE     = 34'd1 << 33
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] mosi;
        logic       cs;
        logic [7:0] rd;
        logic [1:0] st;
    } t_res;

    function automatic logic cs_of(input t_phase p);
        case (p)
            P_IDLE, P_I_GAP, P_I_GAP2, P_I_GAP55, P_I_GAP41, P_SETTLE, P_DONE: cs_of = 1'b0;
            default: cs_of = 1'b1;
        endcase
    endfunction

    function automatic logic is_frame(input t_phase p);
        case (p)
            P_I_CMD0, P_I_CMD55, P_I_ACMD41, P_I_CMD16, P_R_CMD17, P_W_CMD24:
                is_frame = 1'b1;
            default: is_frame = 1'b0;
        endcase
    endfunction

endpackage

[design/sdsh_core.sv]
// Next-state and result logic for one word of the sequencer.
module sdsh_core import sdsh_pkg::*; #(
    parameter int BLOCK_BYTES = 512
) (
    input  t_phase      i_phase,
    input  logic [9:0]  i_step,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_addr,
    input  logic [7:0]  i_prior,
    input  logic [15:0] i_poll,
    input  logic        i_active,
    input  logic        i_align,
    input  logic [15:0] i_limit,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_miso,
    input  logic [22:0] i_blk,
    input  logic [7:0]  i_wbyte,
    output t_phase      o_phase,
    output logic [9:0]  o_step,
    output logic [1:0]  o_op,
    output logic [31:0] o_addr,
    output logic [7:0]  o_prior,
    output logic [15:0] o_poll,
    output logic        o_active,
    output logic [1:0]  o_count,
    output t_res        o_res0,
    output t_res        o_res1
);
    localparam logic [10:0] BLK   = 11'(BLOCK_BYTES);
    localparam logic [31:0] BLK32 = 32'(BLOCK_BYTES);

    function automatic logic [10:0] count_of(input t_phase p);
        case (p)
            P_I_WAKE: count_of = 11'd200;
            P_I_GAP, P_I_GAP2, P_I_GAP41: count_of = 11'd80;
            P_I_GAP55: count_of = 11'd10;
            P_SETTLE: count_of = 11'd2;
            P_I_CMD0, P_I_CMD55, P_I_ACMD41, P_I_CMD16, P_R_CMD17, P_W_CMD24:
                count_of = 11'd8;
            P_I_DUMMY0, P_I_DUM55, P_I_DUM41, P_FINAL, P_R_DUMMY, P_W_DUMMY, P_W_SKIP:
                count_of = 11'd1;
            P_R_DATA: count_of = BLK;
            default: count_of = 11'd0;
        endcase
    endfunction

    function automatic t_phase next_of(input t_phase p, input logic [1:0] op);
        case (p)
            P_I_WAKE: next_of = P_I_GAP;
            P_I_GAP: next_of = P_I_CMD0;
            P_I_CMD0: next_of = P_I_POLL0;
            P_I_DUMMY0: next_of = P_I_GAP2;
            P_I_GAP2: next_of = P_I_CMD55;
            P_I_CMD55: next_of = P_I_POLL55;
            P_I_DUM55: next_of = P_I_GAP55;
            P_I_GAP55: next_of = P_I_ACMD41;
            P_I_ACMD41: next_of = P_I_POLL41;
            P_I_DUM41: next_of = P_I_GAP41;
            P_I_GAP41: next_of = P_I_CMD16;
            P_I_CMD16: next_of = P_I_POLL16;
            P_SETTLE: next_of = (op == 2'd2) ? P_R_CMD17 : P_W_CMD24;
            P_R_CMD17: next_of = P_R_POLL;
            P_R_DUMMY: next_of = P_R_TOKEN;
            P_R_DATA: next_of = P_R_DRAIN;
            P_W_CMD24: next_of = P_W_POLL;
            P_W_DUMMY: next_of = P_W_SKIP;
            P_W_SKIP: next_of = P_W_REQ;
            default: next_of = P_DONE;
        endcase
    endfunction

    function automatic logic [7:0] req_byte(input t_phase p, input logic [9:0] s,
                                            input logic [31:0] addr);
        logic [5:0]  c;
        logic [31:0] a;
        logic [7:0]  crc;
        c   = 6'd24;
        a   = addr;
        crc = 8'hFF;
        case (p)
            P_I_CMD0: begin
                c = 6'd0; a = '0; crc = 8'h95;
            end
            P_I_CMD55: begin
                c = 6'd55; a = '0;
            end
            P_I_ACMD41: begin
                c = 6'd41; a = '0;
            end
            P_I_CMD16: begin
                c = 6'd16; a = BLK32;
            end
            P_R_CMD17: c = 6'd17;
            default: c = 6'd24;
        endcase
        if (!is_frame(p)) begin
            req_byte = 8'hFF;
        end else begin
            case (s)
                10'd1: req_byte = {2'b01, c};
                10'd2: req_byte = a[31:24];
                10'd3: req_byte = a[23:16];
                10'd4: req_byte = a[15:8];
                10'd5: req_byte = a[7:0];
                10'd6: req_byte = crc;
                default: req_byte = 8'hFF;
            endcase
        end
    endfunction

    t_phase      p, nx, np;
    logic        is_poll, hit;
    logic [10:0] cnt, s1;
    logic [15:0] pc1;
    t_res        rd_res, tail;

    always_comb begin
        p       = i_phase;
        is_poll = 1'b1;
        hit     = 1'b0;
        nx      = P_DONE;
        case (p)
            P_I_POLL0: begin
                nx = P_I_DUMMY0; hit = (i_miso == 8'h01);
            end
            P_I_POLL55: begin
                nx = P_I_DUM55; hit = (i_miso != 8'hFF);
            end
            P_I_POLL41: begin
                nx = (i_miso == 8'h00) ? P_I_DUM41 : P_I_CMD55; hit = (i_miso != 8'hFF);
            end
            P_I_POLL16: begin
                nx = P_FINAL; hit = (i_miso == 8'h00);
            end
            P_R_POLL: begin
                nx = P_R_DUMMY; hit = (i_miso == 8'h00);
            end
            P_R_TOKEN: begin
                nx = P_R_DATA; hit = (i_miso == 8'hFE);
            end
            P_R_DRAIN: begin
                nx = P_FINAL; hit = (i_miso == 8'hFF);
            end
            P_W_POLL: begin
                nx = P_W_DUMMY; hit = (i_miso == 8'h00);
            end
            P_W_RESP: begin
                nx = P_W_BUSY; hit = (i_miso != 8'hFF);
            end
            P_W_BUSY: begin
                nx = P_FINAL; hit = (i_miso == 8'hFF);
            end
            default: is_poll = 1'b0;
        endcase
        cnt = count_of(p);
        s1  = {1'b0, i_step} + 11'd1;
        pc1 = i_poll + 16'd1;

        o_phase  = i_phase;
        o_step   = i_step;
        o_op     = i_op;
        o_addr   = i_addr;
        o_prior  = i_prior;
        o_poll   = i_poll;
        o_active = i_active;
        o_count  = 2'd0;
        o_res0   = '0;
        o_res1   = '0;
        rd_res   = '0;
        tail     = '0;
        np       = p;

        case (i_cmd)
            CMD_INIT, CMD_READ, CMD_WRITE: begin
                o_count = 2'd1;
                if (i_active) begin
                    o_res0 = '{kind: K_DONE, mosi: 8'h00, cs: cs_of(p), rd: 8'h00,
                               st: ST_REFUSED};
                end else begin
                    o_active = 1'b1;
                    o_op     = i_cmd[1:0] + 2'd1;
                    o_step   = '0;
                    o_poll   = '0;
                    if (i_cmd == CMD_INIT) begin
                        o_phase = P_I_WAKE;
                    end else begin
                        o_phase = P_SETTLE;
                        o_addr  = 32'(i_blk) * BLK32;
                        o_prior = 8'h01;
                    end
                    o_res0 = '{kind: K_XFER, mosi: 8'hFF, cs: cs_of(o_phase), rd: 8'h00,
                               st: ST_OK};
                end
            end
            CMD_WBYTE: begin
                if (i_active && p == P_W_REQ) begin
                    o_phase = P_W_XFER;
                    o_count = 2'd1;
                    o_res0  = '{kind: K_XFER, mosi: i_wbyte, cs: 1'b1, rd: 8'h00, st: ST_OK};
                end
            end
            CMD_XCHG: begin
                if (i_active && p != P_W_REQ) begin
                    if (p == P_R_DATA) begin
                        o_prior = i_miso;
                        rd_res  = '{kind: K_RDATA, mosi: 8'h00, cs: 1'b1,
                                    rd: i_align ? {i_prior[1:0], i_miso[7:2]} : i_miso,
                                    st: ST_OK};
                    end
                    if (is_poll && hit) begin
                        np = nx; o_step = '0; o_poll = '0;
                    end else if (is_poll) begin
                        o_poll = pc1;
                    end else if (p == P_W_XFER) begin
                        if (s1 >= BLK) begin
                            np = P_W_RESP; o_step = '0; o_poll = '0;
                        end else begin
                            o_step = s1[9:0]; np = P_W_REQ;
                        end
                    end else if (cnt != 11'd0) begin
                        if (s1 >= cnt) begin
                            np = next_of(p, i_op); o_step = '0; o_poll = '0;
                        end else begin
                            o_step = s1[9:0];
                        end
                    end
                    o_phase = np;
                    if (is_poll && !hit && i_limit != 16'd0 && pc1 >= i_limit) begin
                        np = P_DONE;
                        tail = '{kind: K_DONE, mosi: 8'h00, cs: 1'b0, rd: 8'h00,
                                 st: ST_TIMEOUT};
                    end else if (np == P_DONE) begin
                        tail = '{kind: K_DONE, mosi: 8'h00, cs: 1'b0, rd: 8'h00, st: ST_OK};
                    end else if (np == P_W_REQ) begin
                        tail = '{kind: K_WREQ, mosi: 8'h00, cs: 1'b1, rd: 8'h00, st: ST_OK};
                    end else begin
                        tail = '{kind: K_XFER, mosi: req_byte(np, o_step, i_addr),
                                 cs: cs_of(np), rd: 8'h00, st: ST_OK};
                    end
                    if (np == P_DONE) begin
                        o_phase = P_IDLE; o_step = '0; o_poll = '0; o_op = '0;
                        o_active = 1'b0;
                    end
                    if (p == P_R_DATA) begin
                        o_count = 2'd2; o_res0 = rd_res; o_res1 = tail;
                    end else begin
                        o_count = 2'd1; o_res0 = tail;
                    end
                end
            end
            default: o_count = 2'd0;
        endcase
    end
endmodule

[design/sd_spi_host_sequencer_unit.sv]
// Top level of the SD card SPI-mode host sequencer.
// A word is registered on input; its results are registered into the result buffer on fire.
// One word per cycle if each gives one result taken at once; a read byte holds the next.
// The input register refills while results drain, limited by the two-entry result buffer.
// Reset: synchronous active-low, clears sequencer state and buffer; align on, retry limit 0.
module sd_spi_host_sequencer_unit import sdsh_pkg::*; #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_miso_byte,
    input  logic [22:0] i_block_address,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_mosi_byte,
    output logic        o_chip_select_low,
    output logic [7:0]  o_read_byte,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    t_phase      r_phase, n_phase;
    logic [9:0]  r_step, n_step;
    logic [1:0]  r_op, n_op;
    logic [31:0] r_addr, n_addr;
    logic [7:0]  r_prior, n_prior;
    logic [15:0] r_poll, n_poll;
    logic        r_active, n_active;
    logic        r_align;
    logic [15:0] r_limit;
    logic [1:0]  cnt;
    t_res        res0, res1;

    t_res        r_q0, r_q1;
    logic [1:0]  r_qn;
    logic        r_iv;
    logic [2:0]  r_cmd;
    logic [7:0]  r_miso, r_wb;
    logic [22:0] r_blk;
    logic        pop, fire;

    assign o_cfg_ready = 1'b1;

    sdsh_core #(.BLOCK_BYTES(BLOCK_BYTES)) u_core (
        .i_phase(r_phase), .i_step(r_step), .i_op(r_op), .i_addr(r_addr),
        .i_prior(r_prior), .i_poll(r_poll), .i_active(r_active),
        .i_align(r_align), .i_limit(r_limit),
        .i_cmd(r_cmd), .i_miso(r_miso), .i_blk(r_blk), .i_wbyte(r_wb),
        .o_phase(n_phase), .o_step(n_step), .o_op(n_op), .o_addr(n_addr),
        .o_prior(n_prior), .o_poll(n_poll), .o_active(n_active),
        .o_count(cnt), .o_res0(res0), .o_res1(res1)
    );

    assign o_valid = (r_qn != 2'd0);
    assign pop     = o_valid && i_ready;
    assign fire    = r_iv && (r_qn == 2'd0 || (r_qn == 2'd1 && pop));
    assign o_ready = !r_iv || fire;

    assign o_kind            = r_q0.kind;
    assign o_mosi_byte       = r_q0.mosi;
    assign o_chip_select_low = r_q0.cs;
    assign o_read_byte       = r_q0.rd;
    assign o_status          = r_q0.st;
    assign o_last            = (r_qn == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= P_IDLE;
            r_step   <= '0;
            r_op     <= '0;
            r_addr   <= '0;
            r_prior  <= 8'h01;
            r_poll   <= '0;
            r_active <= 1'b0;
            r_align  <= 1'b1;
            r_limit  <= '0;
            r_qn     <= '0;
            r_iv     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_ALIGN) begin
                    r_align <= i_cfg_data[0];
                end else begin
                    r_limit <= i_cfg_data;
                end
            end
            if (o_ready) begin
                r_iv <= i_valid;
            end
            if (fire) begin
                r_phase  <= n_phase;
                r_step   <= n_step;
                r_op     <= n_op;
                r_addr   <= n_addr;
                r_prior  <= n_prior;
                r_poll   <= n_poll;
                r_active <= n_active;
                r_qn     <= cnt;
                r_q0     <= res0;
                r_q1     <= res1;
            end else if (pop) begin
                r_qn <= r_qn - 2'd1;
                r_q0 <= r_q1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd  <= i_command;
            r_miso <= i_miso_byte;
            r_blk  <= i_block_address;
            r_wb   <= i_write_byte;
        end
    end
endmodule

[tb/tb_sd_spi_host_sequencer_unit.sv]
// Testbench for the SD SPI host sequencer: drives init, read and write sessions and checks results.
module tb_sd_spi_host_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sdsh_pkg::*;

    localparam int BLK = 512;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] mosi;
        logic       cs;
        logic [7:0] rd;
        logic [1:0] st;
        logic       lst;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_command = '0;
    logic [7:0]  i_miso_byte = '0;
    logic [22:0] i_block_address = '0;
    logic [7:0]  i_write_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_mosi_byte;
    logic        o_chip_select_low;
    logic [7:0]  o_read_byte;
    logic [1:0]  o_status;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    sd_spi_host_sequencer_unit u_dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic        align_en;
    logic [15:0] retry_lim;
    t_phase      phase;
    int unsigned step;
    logic [1:0]  oper;
    logic [31:0] byte_addr;
    logic [7:0]  prior_raw;
    logic [15:0] polls;
    logic        busy;

    t_word expected_words[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    quiet = 1'b0;
    bit    hold_off = 1'b0;

    function automatic int unsigned phase_len(t_phase p);
        case (p)
            P_I_WAKE: return 200;
            P_I_GAP, P_I_GAP2, P_I_GAP41: return 80;
            P_I_GAP55: return 10;
            P_SETTLE: return 2;
            P_I_CMD0, P_I_CMD55, P_I_ACMD41, P_I_CMD16, P_R_CMD17, P_W_CMD24: return 8;
            P_I_DUMMY0, P_I_DUM55, P_I_DUM41, P_FINAL, P_R_DUMMY, P_W_DUMMY,
            P_W_SKIP: return 1;
            P_R_DATA: return BLK;
            default: return 0;
        endcase
    endfunction

    function automatic t_phase phase_after(t_phase p);
        case (p)
            P_I_WAKE: return P_I_GAP;
            P_I_GAP: return P_I_CMD0;
            P_I_CMD0: return P_I_POLL0;
            P_I_DUMMY0: return P_I_GAP2;
            P_I_GAP2: return P_I_CMD55;
            P_I_CMD55: return P_I_POLL55;
            P_I_DUM55: return P_I_GAP55;
            P_I_GAP55: return P_I_ACMD41;
            P_I_ACMD41: return P_I_POLL41;
            P_I_DUM41: return P_I_GAP41;
            P_I_GAP41: return P_I_CMD16;
            P_I_CMD16: return P_I_POLL16;
            P_SETTLE: return (oper == 2'd2) ? P_R_CMD17 : P_W_CMD24;
            P_R_CMD17: return P_R_POLL;
            P_R_DUMMY: return P_R_TOKEN;
            P_R_DATA: return P_R_DRAIN;
            P_W_CMD24: return P_W_POLL;
            P_W_DUMMY: return P_W_SKIP;
            P_W_SKIP: return P_W_REQ;
            default: return P_DONE;
        endcase
    endfunction

    function automatic logic chip_sel(t_phase p);
        return !(p inside {P_IDLE, P_I_GAP, P_I_GAP2, P_I_GAP55, P_I_GAP41, P_SETTLE, P_DONE});
    endfunction

    function automatic logic [7:0] frame_at(t_phase p, int unsigned s);
        logic [5:0]  c;
        logic [31:0] a;
        logic [7:0]  crc;
        a = '0;
        crc = 8'hFF;
        case (p)
            P_I_CMD0: begin c = 6'd0; crc = 8'h95; end
            P_I_CMD55: c = 6'd55;
            P_I_ACMD41: c = 6'd41;
            P_I_CMD16: begin c = 6'd16; a = BLK; end
            P_R_CMD17: begin c = 6'd17; a = byte_addr; end
            default: begin c = 6'd24; a = byte_addr; end
        endcase
        if (s == 1) return {2'b01, c};
        if (s >= 2 && s <= 5) return 8'(a >> (8 * (5 - s)));
        if (s == 6) return crc;
        return 8'hFF;
    endfunction

    function automatic logic [7:0] out_byte();
        return (phase_len(phase) == 8) ? frame_at(phase, step) : 8'hFF;
    endfunction

    function automatic void enter_phase(t_phase p);
        phase = p;
        step = 0;
        polls = '0;
    endfunction

    function automatic void go_idle();
        enter_phase(P_IDLE);
        oper = '0;
        busy = 1'b0;
    endfunction

    function automatic void push(logic [1:0] k, logic [7:0] m, logic c, logic [7:0] r,
                                 logic [1:0] s, logic l);
        expected_words.push_back({k, m, c, r, s, l});
    endfunction

    // returns -1 when p is not a reply wait
    function automatic int reply_match(t_phase p, logic [7:0] m, output t_phase nx);
        nx = P_DONE;
        case (p)
            P_I_POLL0: begin nx = P_I_DUMMY0; return m == 8'h01; end
            P_I_POLL55: begin nx = P_I_DUM55; return m != 8'hFF; end
            P_I_POLL41: begin nx = (m == 8'h00) ? P_I_DUM41 : P_I_CMD55; return m != 8'hFF; end
            P_I_POLL16: begin nx = P_FINAL; return m == 8'h00; end
            P_R_POLL: begin nx = P_R_DUMMY; return m == 8'h00; end
            P_R_TOKEN: begin nx = P_R_DATA; return m == 8'hFE; end
            P_R_DRAIN: begin nx = P_FINAL; return m == 8'hFF; end
            P_W_POLL: begin nx = P_W_DUMMY; return m == 8'h00; end
            P_W_RESP: begin nx = P_W_BUSY; return m != 8'hFF; end
            P_W_BUSY: begin nx = P_FINAL; return m == 8'hFF; end
            default: return -1;
        endcase
    endfunction

    function automatic void exchange_step(logic [7:0] m);
        t_phase p, nx;
        int     pr;
        int unsigned n;
        p = phase;
        if (p == P_R_DATA) begin
            push(K_RDATA, 8'h00, 1'b1, align_en ? {prior_raw[1:0], m[7:2]} : m, ST_OK, 1'b0);
            prior_raw = m;
        end
        pr = reply_match(p, m, nx);
        n = phase_len(p);
        if (pr == 1) begin
            enter_phase(nx);
        end else if (pr == 0) begin
            polls = polls + 16'd1;
            if (retry_lim != 16'd0 && polls >= retry_lim) begin
                go_idle();
                push(K_DONE, 8'h00, 1'b0, 8'h00, ST_TIMEOUT, 1'b1);
                return;
            end
        end else if (p == P_W_XFER) begin
            if (step + 1 >= BLK) enter_phase(P_W_RESP);
            else begin step = step + 1; phase = P_W_REQ; end
        end else if (n != 0) begin
            if (step + 1 >= n) enter_phase(phase_after(p));
            else step = step + 1;
        end
        if (phase == P_DONE) begin
            go_idle();
            push(K_DONE, 8'h00, 1'b0, 8'h00, ST_OK, 1'b1);
        end else if (phase == P_W_REQ) push(K_WREQ, 8'h00, 1'b1, 8'h00, ST_OK, 1'b1);
        else push(K_XFER, out_byte(), chip_sel(phase), 8'h00, ST_OK, 1'b1);
    endfunction

    function automatic void predict_word(logic [2:0] c, logic [7:0] m, logic [22:0] a,
                                         logic [7:0] w);
        if (c <= CMD_WRITE) begin
            if (busy) begin
                push(K_DONE, 8'h00, chip_sel(phase), 8'h00, ST_REFUSED, 1'b1);
                return;
            end
            busy = 1'b1;
            oper = c[1:0] + 2'd1;
            if (c == CMD_INIT) enter_phase(P_I_WAKE);
            else begin
                byte_addr = a * BLK;
                prior_raw = 8'h01;
                enter_phase(P_SETTLE);
            end
            push(K_XFER, out_byte(), chip_sel(phase), 8'h00, ST_OK, 1'b1);
        end else if (c == CMD_WBYTE) begin
            if (busy && phase == P_W_REQ) begin
                phase = P_W_XFER;
                push(K_XFER, w, 1'b1, 8'h00, ST_OK, 1'b1);
            end
        end else if (c == CMD_XCHG) begin
            if (busy && phase != P_W_REQ) exchange_step(m);
        end
    endfunction

    task automatic report(string what, t_word got, t_word exp);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_word got, exp;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_kind, o_mosi_byte, o_chip_select_low, o_read_byte, o_status, o_last};
            if (expected_words.size() == 0) report("unexpected word", got, '0);
            else begin
                exp = expected_words.pop_front();
                if (got.kind != exp.kind) report("kind", got, exp);
                else if (got.mosi != exp.mosi) report("mosi_byte", got, exp);
                else if (got.cs != exp.cs) report("chip_select_low", got, exp);
                else if (got.rd != exp.rd) report("read_byte", got, exp);
                else if (got.st != exp.st) report("status", got, exp);
                else if (got.lst != exp.lst) report("last", got, exp);
            end
        end
    end

    // receiver stalls
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) i_ready <= 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 10);
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_ready <= 1'b1;
            end else i_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || hold_off)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_sd_spi_host_sequencer_unit failed");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] c, logic [7:0] m = '0, logic [22:0] a = '0,
                             logic [7:0] w = '0);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= c;
        i_miso_byte <= m;
        i_block_address <= a;
        i_write_byte <= w;
        do @(posedge i_clk); while (!o_ready);
        predict_word(c, m, a, w);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] d);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ALIGN) align_en = d[0];
        else retry_lim = d;
    endtask

    // answer what the card would send for the current phase
    function automatic logic [7:0] card_reply(int noise);
        if ($urandom_range(0, 99) < noise) return 8'($urandom);
        case (phase)
            P_I_POLL0: return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h01;
            P_I_POLL41: return ($urandom_range(0, 2) == 0) ? 8'h01 : 8'h00;
            P_I_POLL55, P_I_POLL16, P_R_POLL, P_W_POLL:
                return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00;
            P_R_TOKEN: return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'hFE;
            P_W_RESP: return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h05;
            P_R_DRAIN, P_W_BUSY: return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_session(logic [2:0] c, logic [22:0] a, int noise, int cap);
        int k;
        k = 0;
        send_word(c, 8'h00, a, 8'h00);
        while (busy && k < cap) begin
            if (phase == P_W_REQ) begin
                if ($urandom_range(0, 19) == 0) send_word(CMD_XCHG, 8'($urandom));
                send_word(CMD_WBYTE, 8'h00, 23'd0, 8'($urandom));
            end else send_word(CMD_XCHG, card_reply(noise));
            if ($urandom_range(0, 199) == 0)
                send_word(3'($urandom_range(0, 2)), 8'h00, 23'($urandom));
            k++;
        end
    endtask

    task automatic test_directed();
        send_word(CMD_XCHG, 8'hFF);
        send_word(CMD_WBYTE, 8'h00, 23'd0, 8'hAA);
        send_word(3'd5);
        send_word(3'd7, 8'hFF, '1, 8'hFF);
        send_word(CMD_READ, 8'h00, 23'h7FFFFF);
        send_word(CMD_INIT);
        send_word(CMD_WRITE, 8'h00, 23'h000001);
        repeat (10) send_word(CMD_XCHG, 8'hFF);
        send_word(CMD_WBYTE, 8'h00, 23'd0, 8'h00);
        write_reg(REG_RETRY, 16'd1);
        send_word(CMD_XCHG, 8'hFF);
        send_word(CMD_XCHG, 8'hFF);
        send_word(CMD_XCHG, 8'hFF);
        send_word(CMD_XCHG, 8'hFF);
    endtask

    task automatic test_init();
        write_reg(REG_RETRY, 16'd0);
        run_session(CMD_INIT, 23'd0, 2, 2000);
    endtask

    task automatic test_read(logic align);
        write_reg(REG_ALIGN, {15'd0, align});
        run_session(CMD_READ, 23'($urandom), 3, 2000);
    endtask

    task automatic test_timeouts();
        write_reg(REG_RETRY, 16'd3);
        run_session(CMD_READ, 23'($urandom), 100, 600);
        run_session(CMD_WRITE, 23'($urandom), 100, 600);
    endtask

    task automatic test_backpressure();
        write_reg(REG_ALIGN, 16'd0);
        hold_off = 1'b1;
        fork
            begin
                send_word(CMD_READ, 8'h00, 23'h12345);
                repeat (6) send_word(CMD_XCHG, 8'($urandom));
            end
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        while (busy) send_word(CMD_XCHG, card_reply(5));
    endtask

    task automatic test_tail();
        write_reg(REG_RETRY, 16'd0);
        quiet = 1'b1;
        run_session(CMD_WRITE, 23'($urandom), 0, 3000);
    endtask

    initial begin
        int t;
        align_en = 1'b1;
        retry_lim = '0;
        prior_raw = 8'h01;
        byte_addr = '0;
        oper = '0;
        go_idle();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_init();
        test_read(1'b1);
        test_timeouts();
        test_backpressure();
        test_tail();
        drain();
        t = 0;
        while (expected_words.size() != 0 && t < 1000) begin
            @(posedge i_clk);
            t++;
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("tb_sd_spi_host_sequencer_unit passed");
        else
            $display("tb_sd_spi_host_sequencer_unit failed");
        $finish;
    end
endmodule
